[rtl/avm_pkg.sv]
// ----------------------------------------------------------------------------
// avm_pkg
// Shared widths, opcodes, status codes and limits of the accumulator machine
// execute core.
// ----------------------------------------------------------------------------
package avm_pkg;

	// Field widths
	localparam int OP_W   = 8;
	localparam int PC_W   = 32;
	localparam int ACC_W  = 11;
	localparam int ST_W   = 3;
	localparam int DIG_W  = 2;

	// Default sizes
	localparam int MEM_CELLS_DEF   = 1000;
	localparam int STACK_DEPTH_DEF = 100;

	// Saturation limits
	localparam logic signed [ACC_W:0] ACC_MAX = 12'sd999;
	localparam logic signed [ACC_W:0] ACC_MIN = -12'sd999;

	// Return from call resumes past the call's operand
	localparam logic [PC_W-1:0] OPERAND_SKIP = 32'd5;

	// Digit selector codes
	localparam logic [DIG_W-1:0] DIG_ONES     = 2'd0;
	localparam logic [DIG_W-1:0] DIG_TENS     = 2'd1;
	localparam logic [DIG_W-1:0] DIG_HUNDREDS = 2'd2;

	// Run status codes
	localparam logic [ST_W-1:0] ST_RUN  = 3'd0;
	localparam logic [ST_W-1:0] ST_STOP = 3'd1;
	localparam logic [ST_W-1:0] ST_END  = 3'd2;
	localparam logic [ST_W-1:0] ST_OVF  = 3'd3;
	localparam logic [ST_W-1:0] ST_UNF  = 3'd4;

	// Opcodes
	localparam logic [OP_W-1:0] OP_STOP     = 8'd0;
	localparam logic [OP_W-1:0] OP_JUMP     = 8'd1;
	localparam logic [OP_W-1:0] OP_CALL     = 8'd2;
	localparam logic [OP_W-1:0] OP_RET      = 8'd3;
	localparam logic [OP_W-1:0] OP_CUR_R    = 8'd4;
	localparam logic [OP_W-1:0] OP_CUR_L    = 8'd5;
	localparam logic [OP_W-1:0] OP_DIG_UP   = 8'd6;
	localparam logic [OP_W-1:0] OP_DIG_DN   = 8'd7;
	localparam logic [OP_W-1:0] OP_CLR_POS  = 8'd8;
	localparam logic [OP_W-1:0] OP_LOAD     = 8'd9;
	localparam logic [OP_W-1:0] OP_SWAP_MEM = 8'd10;
	localparam logic [OP_W-1:0] OP_TO_BAK   = 8'd11;
	localparam logic [OP_W-1:0] OP_SWAP_BAK = 8'd12;
	localparam logic [OP_W-1:0] OP_ADD_DIG  = 8'd13;
	localparam logic [OP_W-1:0] OP_SUB_DIG  = 8'd14;
	localparam logic [OP_W-1:0] OP_ADD_BAK  = 8'd15;
	localparam logic [OP_W-1:0] OP_NEG      = 8'd16;
	localparam logic [OP_W-1:0] OP_CLR_ACC  = 8'd17;
	localparam logic [OP_W-1:0] OP_RAND     = 8'd18;
	localparam logic [OP_W-1:0] OP_CMP_EQZ  = 8'd19;
	localparam logic [OP_W-1:0] OP_CMP_NEZ  = 8'd20;
	localparam logic [OP_W-1:0] OP_CMP_GTZ  = 8'd21;
	localparam logic [OP_W-1:0] OP_CMP_LTZ  = 8'd22;
	localparam logic [OP_W-1:0] OP_CMP_OVF  = 8'd23;
	localparam logic [OP_W-1:0] OP_SKIP     = 8'd24;
	localparam logic [OP_W-1:0] OP_USER     = 8'd25;
	localparam logic [OP_W-1:0] OP_EMIT     = 8'd26;
	localparam logic [OP_W-1:0] OP_PAUSE    = 8'd27;
	localparam logic [OP_W-1:0] OP_END      = 8'd255;

endpackage

[rtl/avm_ifs.sv]
// ----------------------------------------------------------------------------
// avm_ifs
// Valid/ready channels of the execute core: instruction in, result out.
// ----------------------------------------------------------------------------
interface avm_in_if import avm_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         opcode;
	logic [PC_W-1:0]         target;
	logic signed [ACC_W-1:0] number;

	modport source (output valid, output opcode, output target, output number, input ready);
	modport sink   (input valid, input opcode, input target, input number, output ready);
endinterface

interface avm_out_if import avm_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [PC_W-1:0]         next_pc;
	logic signed [ACC_W-1:0] acc_value;
	logic [ST_W-1:0]         status;
	logic                    char_valid;
	logic                    pause_request;
	logic                    compare_flag;
	logic                    overflow_flag;

	modport source (output valid, output next_pc, output acc_value, output status,
		output char_valid, output pause_request, output compare_flag,
		output overflow_flag, input ready);
	modport sink   (input valid, input next_pc, input acc_value, input status,
		input char_valid, input pause_request, input compare_flag,
		input overflow_flag, output ready);
endinterface

[rtl/avm_ram.sv]
// ----------------------------------------------------------------------------
// avm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module avm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/accumulator_vm_execute_core.sv]
// ----------------------------------------------------------------------------
// accumulator_vm_execute_core
// Execute unit of a small accumulator machine: one instruction per request.
// ----------------------------------------------------------------------------
// Each accepted instruction gives one result, and while the result channel
// does not stall, a new instruction can be accepted every cycle, so the
// sustained rate is one instruction per clock. On acceptance the reads of
// the data RAM (at the cursor) and of the return-stack RAM (at the pop slot)
// are issued using the register state that the previous instruction leaves;
// the execute stage then executes, writes back and loads the result register.
// A write by one instruction to the entry the next one reads is forwarded.
// After reset the data RAM is cleared, one cell per cycle; no instruction is
// accepted while it clears. Return-stack entries never written read as zero.
// Once stop, end of program or a stack fault halts the core, every further
// instruction only repeats the halted state until reset.
module accumulator_vm_execute_core import avm_pkg::*; #(
	parameter int MEM_CELLS   = MEM_CELLS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	avm_in_if.sink     instr,
	avm_out_if.source  result
);

	localparam int CUR_W = $clog2(MEM_CELLS);
	localparam int SP_W  = $clog2(STACK_DEPTH);
	localparam logic [CUR_W-1:0] CUR_LAST = CUR_W'(MEM_CELLS - 1);
	localparam logic [SP_W-1:0]  SP_TOP   = SP_W'(STACK_DEPTH - 1);

	// Architectural registers
	logic signed [ACC_W-1:0] acc_q, bak_q;
	logic [PC_W-1:0]         pc_q;
	logic [SP_W-1:0]         sp_q;
	logic [CUR_W-1:0]        cur_q;
	logic [DIG_W-1:0]        dig_q;
	logic                    ovf_q, cmp_q, halt_q;
	logic [ST_W-1:0]         hcode_q;

	// Clearing pass
	logic             clr_active_q;
	logic [CUR_W-1:0] clr_cnt_q;

	// Execute stage
	logic                    vld_s1;
	logic [OP_W-1:0]         op_s1;
	logic [PC_W-1:0]         tgt_s1;
	logic signed [ACC_W-1:0] num_s1;
	logic                    dm_fwd_s1, st_fwd_s1, st_vld_s1;
	logic [ACC_W-1:0]        dm_fdat_s1;
	logic [PC_W-1:0]         st_fdat_s1;

	// Return-stack valid bits
	logic [STACK_DEPTH-1:0]  st_written_q;

	// Result register
	logic out_vld_q;

	// Handshake
	logic in_acc, s1_fire;

	// RAM ports
	logic                    dm_we, dm_re;
	logic [CUR_W-1:0]        dm_waddr, dm_raddr;
	logic [ACC_W-1:0]        dm_wdata, dm_rdata;
	logic                    st_we, st_re;
	logic [SP_W-1:0]         st_waddr, st_raddr;
	logic [PC_W-1:0]         st_rdata;

	// Execute results
	logic signed [ACC_W-1:0] nx_acc, nx_bak;
	logic [PC_W-1:0]         nx_pc;
	logic [SP_W-1:0]         nx_sp, sp_rd;
	logic [CUR_W-1:0]        nx_cur;
	logic [DIG_W-1:0]        nx_dig;
	logic                    nx_ovf, nx_cmp, nx_halt;
	logic [ST_W-1:0]         nx_hcode;
	logic                    nx_chr, nx_pause, ex_dm_we, ex_st_we;
	logic signed [ACC_W-1:0] mem_val;
	logic [PC_W-1:0]         pop_val;
	logic signed [ACC_W:0]   acc_ext, dig_val, sum_dig, dif_dig, sum_bak;

	assign s1_fire     = vld_s1 && (!out_vld_q || result.ready);
	assign instr.ready = !clr_active_q && (!vld_s1 || s1_fire);
	assign in_acc      = instr.valid && instr.ready;

	// Operand data with forwarding of the previous write
	assign mem_val = dm_fwd_s1 ? dm_fdat_s1 : dm_rdata;
	assign pop_val = !st_vld_s1 ? '0 : (st_fwd_s1 ? st_fdat_s1 : st_rdata);

	// Arithmetic operands
	always_comb begin
		acc_ext = {acc_q[ACC_W-1], acc_q};
		unique case (dig_q)
			DIG_TENS:     dig_val = 12'sd10;
			DIG_HUNDREDS: dig_val = 12'sd100;
			default:      dig_val = 12'sd1;
		endcase
		sum_dig = acc_ext + dig_val;
		dif_dig = acc_ext - dig_val;
		sum_bak = acc_ext + {bak_q[ACC_W-1], bak_q};
	end

	// Instruction execute
	always_comb begin
		nx_acc   = acc_q;
		nx_bak   = bak_q;
		nx_pc    = pc_q + 32'd1;
		nx_sp    = sp_q;
		nx_cur   = cur_q;
		nx_dig   = dig_q;
		nx_ovf   = ovf_q;
		nx_cmp   = cmp_q;
		nx_halt  = halt_q;
		nx_hcode = hcode_q;
		nx_chr   = 1'b0;
		nx_pause = 1'b0;
		ex_dm_we = 1'b0;
		ex_st_we = 1'b0;
		if (halt_q) begin
			nx_pc = pc_q;
		end else begin
			unique case (op_s1)
				OP_STOP: begin
					nx_halt = 1'b1; nx_hcode = ST_STOP; nx_pc = pc_q;
				end
				OP_JUMP: nx_pc = tgt_s1;
				OP_CALL: begin
					ex_st_we = 1'b1;
					if (sp_q == '0) begin
						nx_sp = SP_TOP; nx_halt = 1'b1; nx_hcode = ST_OVF; nx_pc = pc_q;
					end else begin
						nx_sp = sp_q - 1'b1; nx_pc = tgt_s1;
					end
				end
				OP_RET: begin
					if (sp_q >= SP_TOP) begin
						nx_sp = '0; nx_halt = 1'b1; nx_hcode = ST_UNF; nx_pc = pc_q;
					end else begin
						nx_sp = sp_q + 1'b1; nx_pc = pop_val + OPERAND_SKIP;
					end
				end
				OP_CUR_R:    if (cur_q < CUR_LAST) nx_cur = cur_q + 1'b1;
				OP_CUR_L:    if (cur_q != '0) nx_cur = cur_q - 1'b1;
				OP_DIG_UP:   if (dig_q < DIG_HUNDREDS) nx_dig = dig_q + 1'b1;
				OP_DIG_DN:   if (dig_q != DIG_ONES) nx_dig = dig_q - 1'b1;
				OP_CLR_POS: begin
					nx_dig = DIG_ONES; nx_cur = '0;
				end
				OP_LOAD:     nx_acc = mem_val;
				OP_SWAP_MEM: begin
					nx_acc = mem_val; ex_dm_we = 1'b1;
				end
				OP_TO_BAK:   nx_bak = acc_q;
				OP_SWAP_BAK: begin
					nx_acc = bak_q; nx_bak = acc_q;
				end
				OP_ADD_DIG: begin
					if (sum_dig > ACC_MAX) begin
						nx_acc = ACC_MAX[ACC_W-1:0]; nx_ovf = 1'b1;
					end else begin
						nx_acc = sum_dig[ACC_W-1:0]; nx_ovf = 1'b0;
					end
				end
				OP_SUB_DIG: begin
					if (dif_dig < ACC_MIN) begin
						nx_acc = ACC_MIN[ACC_W-1:0]; nx_ovf = 1'b1;
					end else begin
						nx_acc = dif_dig[ACC_W-1:0]; nx_ovf = 1'b0;
					end
				end
				OP_ADD_BAK: begin
					if (sum_bak > ACC_MAX) begin
						nx_acc = ACC_MAX[ACC_W-1:0]; nx_ovf = 1'b1;
					end else if (sum_bak < ACC_MIN) begin
						nx_acc = ACC_MIN[ACC_W-1:0]; nx_ovf = 1'b1;
					end else begin
						nx_acc = sum_bak[ACC_W-1:0]; nx_ovf = 1'b0;
					end
				end
				OP_NEG:      nx_acc = -acc_q;
				OP_CLR_ACC:  nx_acc = '0;
				OP_RAND:     nx_acc = num_s1;
				OP_CMP_EQZ:  nx_cmp = (acc_q == '0);
				OP_CMP_NEZ:  nx_cmp = (acc_q != '0);
				OP_CMP_GTZ:  nx_cmp = (acc_q > 11'sd0);
				OP_CMP_LTZ:  nx_cmp = acc_q[ACC_W-1];
				OP_CMP_OVF:  nx_cmp = ovf_q;
				OP_SKIP:     nx_pc = cmp_q ? (pc_q + OPERAND_SKIP) : tgt_s1;
				OP_USER:     nx_acc = num_s1;
				OP_EMIT:     nx_chr = 1'b1;
				OP_PAUSE:    nx_pause = 1'b1;
				OP_END: begin
					nx_halt = 1'b1; nx_hcode = ST_END; nx_pc = pc_q;
				end
				default: ;
			endcase
		end
	end

	// RAM port control; reads use the state the executing instruction leaves
	always_comb begin
		dm_we    = clr_active_q || (s1_fire && ex_dm_we);
		dm_waddr = clr_active_q ? clr_cnt_q : cur_q;
		dm_wdata = clr_active_q ? '0 : acc_q;
		dm_re    = in_acc;
		dm_raddr = s1_fire ? nx_cur : cur_q;
		st_we    = s1_fire && ex_st_we;
		st_waddr = sp_q;
		st_re    = in_acc;
		sp_rd    = s1_fire ? nx_sp : sp_q;
		st_raddr = (sp_rd >= SP_TOP) ? '0 : sp_rd + 1'b1;
	end

	avm_ram #(.WIDTH(ACC_W), .DEPTH(MEM_CELLS)) u_data_ram (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (dm_raddr),
		.rdata (dm_rdata)
	);

	avm_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (pc_q),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Clearing pass of the data RAM after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == CUR_LAST) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Return-stack written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_written_q <= '0;
		end else if (st_we) begin
			st_written_q[st_waddr] <= 1'b1;
		end
	end

	// Execute stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// Execute stage payload and forwarding capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= instr.opcode;
			tgt_s1     <= instr.target;
			num_s1     <= instr.number;
			dm_fwd_s1  <= dm_we && (dm_waddr == dm_raddr);
			dm_fdat_s1 <= dm_wdata;
			st_fwd_s1  <= st_we && (st_waddr == st_raddr);
			st_fdat_s1 <= pc_q;
			st_vld_s1  <= st_written_q[st_raddr] || (st_we && (st_waddr == st_raddr));
		end
	end

	// Architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			bak_q   <= '0;
			pc_q    <= '0;
			sp_q    <= SP_TOP;
			cur_q   <= '0;
			dig_q   <= DIG_ONES;
			ovf_q   <= 1'b0;
			cmp_q   <= 1'b0;
			halt_q  <= 1'b0;
			hcode_q <= ST_RUN;
		end else if (s1_fire) begin
			acc_q   <= nx_acc;
			bak_q   <= nx_bak;
			pc_q    <= nx_pc;
			sp_q    <= nx_sp;
			cur_q   <= nx_cur;
			dig_q   <= nx_dig;
			ovf_q   <= nx_ovf;
			cmp_q   <= nx_cmp;
			halt_q  <= nx_halt;
			hcode_q <= nx_hcode;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			result.next_pc       <= nx_pc;
			result.acc_value     <= nx_acc;
			result.status        <= nx_halt ? nx_hcode : ST_RUN;
			result.char_valid    <= nx_chr;
			result.pause_request <= nx_pause;
			result.compare_flag  <= nx_cmp;
			result.overflow_flag <= nx_ovf;
		end
	end

	assign result.valid = out_vld_q;

`ifndef SYNTHESIS
	// No request is taken while the data RAM is being cleared
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !instr.ready)
		else $error("instruction accepted during clearing pass");

	// A halted core stays halted
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt released without reset");

	// A halted core writes neither RAM from the execute stage
	a_halt_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && halt_q) |-> (!st_we && !(dm_we && !clr_active_q)))
		else $error("RAM written while halted");

	// Stack pointer and cursor stay inside their stores
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q <= SP_TOP) && (cur_q <= CUR_LAST))
		else $error("stack pointer or cursor out of range");
`endif

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the accumulator machine execute core. A queue of instructions
// (a directed opening, random code with subroutine bursts, a full climb of
// the return stack, a cursor walk over all of data memory, and one halting
// event at the end) drives the instruction channel with random gaps. Every
// accepted instruction runs through a local execute model, and each result
// taken under random backpressure is compared field by field.
// ----------------------------------------------------------------------------
module tb_top import avm_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MEM_N = MEM_CELLS_DEF;
	localparam int STK_N = STACK_DEPTH_DEF;

	typedef struct {
		logic [OP_W-1:0]         opcode;
		logic [PC_W-1:0]         target;
		logic signed [ACC_W-1:0] number;
		bit                      drain;
	} instr_t;

	typedef struct {
		logic [PC_W-1:0]         next_pc;
		logic signed [ACC_W-1:0] acc_value;
		logic [ST_W-1:0]         status;
		logic                    char_valid;
		logic                    pause_request;
		logic                    compare_flag;
		logic                    overflow_flag;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	avm_in_if  instr_if ();
	avm_out_if result_if ();

	accumulator_vm_execute_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_if),
		.result (result_if)
	);

	// Clock, 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Machine state as predicted
	logic signed [ACC_W-1:0] m_acc = '0;
	logic signed [ACC_W-1:0] m_bak = '0;
	logic [PC_W-1:0]         m_pc  = '0;
	int                      m_sp  = STK_N - 1;
	logic [PC_W-1:0]         m_stack [STK_N];
	logic signed [ACC_W-1:0] m_mem [MEM_N];
	int                      m_cur = 0;
	logic [DIG_W-1:0]        m_dig = DIG_ONES;
	bit                      m_ovf = 1'b0;
	bit                      m_cmp = 1'b0;
	bit                      m_halt = 1'b0;
	logic [ST_W-1:0]         m_code = ST_RUN;

	instr_t  instr_q[$];
	result_t expected_results[$];
	int      mismatches = 0;
	int      gen_depth = 0;
	bit      in_fire = 1'b0;
	bit      calm = 1'b0;
	int      send_gap = 0;
	int      recv_gap = 0;
	int      cyc = 0;

	logic signed [ACC_W-1:0] corner_nums [6] = '{-1024, 1023, -999, 999, 0, -1};

	// Execute one instruction on the predicted state
	function automatic result_t exec_instr(input instr_t it);
		logic [PC_W-1:0]         nxt;
		int                      sum;
		int                      step;
		logic signed [ACC_W-1:0] tmp;
		result_t                 r;
		nxt = m_pc + 1;
		r.char_valid = 1'b0;
		r.pause_request = 1'b0;
		step = (m_dig == DIG_TENS) ? 10 : (m_dig == DIG_HUNDREDS) ? 100 : 1;
		if (m_halt) begin
			nxt = m_pc;
		end else begin
			case (it.opcode)
				OP_STOP: begin
					m_halt = 1'b1; m_code = ST_STOP; nxt = m_pc;
				end
				OP_JUMP: nxt = it.target;
				OP_CALL: begin
					m_stack[m_sp] = m_pc;
					if (m_sp == 0) begin
						m_sp = STK_N - 1;
						m_halt = 1'b1; m_code = ST_OVF; nxt = m_pc;
					end else begin
						m_sp--;
						nxt = it.target;
					end
				end
				OP_RET: begin
					if (m_sp == STK_N - 1) begin
						m_sp = 0;
						m_halt = 1'b1; m_code = ST_UNF; nxt = m_pc;
					end else begin
						m_sp++;
						nxt = m_stack[m_sp] + OPERAND_SKIP;
					end
				end
				OP_CUR_R: if (m_cur < MEM_N - 1) m_cur++;
				OP_CUR_L: if (m_cur > 0) m_cur--;
				OP_DIG_UP: if (m_dig < DIG_HUNDREDS) m_dig = m_dig + 1'b1;
				OP_DIG_DN: if (m_dig > DIG_ONES) m_dig = m_dig - 1'b1;
				OP_CLR_POS: begin
					m_dig = DIG_ONES; m_cur = 0;
				end
				OP_LOAD: m_acc = m_mem[m_cur];
				OP_SWAP_MEM: begin
					tmp = m_acc; m_acc = m_mem[m_cur]; m_mem[m_cur] = tmp;
				end
				OP_TO_BAK: m_bak = m_acc;
				OP_SWAP_BAK: begin
					tmp = m_acc; m_acc = m_bak; m_bak = tmp;
				end
				OP_ADD_DIG: begin
					sum = int'(m_acc) + step;
					m_ovf = (sum > ACC_MAX);
					m_acc = m_ovf ? ACC_MAX[ACC_W-1:0] : sum[ACC_W-1:0];
				end
				OP_SUB_DIG: begin
					sum = int'(m_acc) - step;
					m_ovf = (sum < ACC_MIN);
					m_acc = m_ovf ? ACC_MIN[ACC_W-1:0] : sum[ACC_W-1:0];
				end
				OP_ADD_BAK: begin
					// saturates both ways, flag set either way
					sum = int'(m_acc) + int'(m_bak);
					if (sum > ACC_MAX) begin
						m_acc = ACC_MAX[ACC_W-1:0]; m_ovf = 1'b1;
					end else if (sum < ACC_MIN) begin
						m_acc = ACC_MIN[ACC_W-1:0]; m_ovf = 1'b1;
					end else begin
						m_acc = sum[ACC_W-1:0]; m_ovf = 1'b0;
					end
				end
				OP_NEG: m_acc = -m_acc;
				OP_CLR_ACC: m_acc = '0;
				OP_RAND, OP_USER: m_acc = it.number;
				OP_CMP_EQZ: m_cmp = (m_acc == 0);
				OP_CMP_NEZ: m_cmp = (m_acc != 0);
				OP_CMP_GTZ: m_cmp = (m_acc > 0);
				OP_CMP_LTZ: m_cmp = (m_acc < 0);
				OP_CMP_OVF: m_cmp = m_ovf;
				OP_SKIP: nxt = m_cmp ? m_pc + OPERAND_SKIP : it.target;
				OP_EMIT: r.char_valid = 1'b1;
				OP_PAUSE: r.pause_request = 1'b1;
				OP_END: begin
					m_halt = 1'b1; m_code = ST_END; nxt = m_pc;
				end
				default: ;
			endcase
			m_pc = nxt;
		end
		r.next_pc = nxt;
		r.acc_value = m_acc;
		r.status = m_halt ? m_code : ST_RUN;
		r.compare_flag = m_cmp;
		r.overflow_flag = m_ovf;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Gap length: mostly short, a few long, none during calm stretches
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic signed [ACC_W-1:0] rand_num();
		if ($urandom_range(0, 9) < 2) return corner_nums[$urandom_range(0, 5)];
		return ACC_W'($urandom());
	endfunction

	task automatic push_instr(input logic [OP_W-1:0] op, input logic [PC_W-1:0] tgt,
		input logic signed [ACC_W-1:0] num, input bit drain);
		instr_t it;
		it.opcode = op;
		it.target = tgt;
		it.number = num;
		it.drain = drain;
		instr_q.push_back(it);
	endtask

	task automatic push_call(input bit drain);
		gen_depth++;
		push_instr(OP_CALL, $urandom(), rand_num(), drain);
	endtask

	task automatic push_ret();
		gen_depth--;
		push_instr(OP_RET, $urandom(), rand_num(), 1'b0);
	endtask

	// Random non-halting instruction; keeps the return stack in bounds
	task automatic push_random_op();
		logic [OP_W-1:0] op;
		if ($urandom_range(0, 99) < 8)
			op = OP_W'($urandom_range(OP_PAUSE + 1, OP_END - 1));
		else
			op = OP_W'($urandom_range(OP_JUMP, OP_PAUSE));
		if (op == OP_CALL && gen_depth >= STK_N - 1) op = OP_RET;
		else if (op == OP_RET && gen_depth == 0) op = OP_CALL;
		if (op == OP_CALL) push_call(1'b0);
		else if (op == OP_RET) push_ret();
		else push_instr(op, $urandom(), rand_num(), 1'b0);
	endtask

	// Random code with occasional nested subroutine bursts
	task automatic push_random_block(input int n);
		int stop_at;
		int k;
		int j;
		stop_at = instr_q.size() + n;
		while (instr_q.size() < stop_at) begin
			if ($urandom_range(0, 99) < 10) begin
				k = $urandom_range(1, 6);
				for (j = 0; j < k && gen_depth < STK_N - 1; j++) begin
					push_call(1'b0);
					repeat ($urandom_range(0, 4)) push_random_op();
				end
				while (j > 0 && gen_depth > 0) begin
					push_ret();
					j--;
				end
			end else begin
				push_random_op();
			end
		end
	endtask

	// Reset and initial drive
	initial begin
		arst_n = 1'b0;
		instr_if.valid = 1'b0;
		instr_if.opcode = '0;
		instr_if.target = '0;
		instr_if.number = '0;
		result_if.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Instruction driver and result ready, both at the falling edge
	always @(negedge clk) begin : drive_proc
		instr_t it;
		bit     v;
		cyc++;
		if (cyc % 300 == 0) calm = ($urandom_range(0, 3) == 0);
		if (!arst_n) begin
			instr_if.valid <= 1'b0;
			result_if.ready <= 1'b0;
		end else begin
			if (!(instr_if.valid && !in_fire)) begin
				v = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (instr_q.size() > 0 &&
					!(instr_q[0].drain && expected_results.size() != 0)) begin
					it = instr_q.pop_front();
					instr_if.opcode <= it.opcode;
					instr_if.target <= it.target;
					instr_if.number <= it.number;
					v = 1'b1;
					send_gap = pick_gap();
				end
				instr_if.valid <= v;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	// Monitor: check results first, then predict the newly accepted request
	always @(posedge clk) begin : watch_proc
		result_t exp_r;
		instr_t  got;
		in_fire = 1'b0;
		if (arst_n) begin
			in_fire = instr_if.valid && instr_if.ready;
			if (result_if.valid && result_if.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, next_pc %0h", $time,
						result_if.next_pc);
					mismatches++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("next_pc", exp_r.next_pc, result_if.next_pc);
					check_field("acc_value", 32'(exp_r.acc_value),
						32'(result_if.acc_value));
					check_field("status", 32'(exp_r.status), 32'(result_if.status));
					check_field("char_valid", 32'(exp_r.char_valid),
						32'(result_if.char_valid));
					check_field("pause_request", 32'(exp_r.pause_request),
						32'(result_if.pause_request));
					check_field("compare_flag", 32'(exp_r.compare_flag),
						32'(result_if.compare_flag));
					check_field("overflow_flag", 32'(exp_r.overflow_flag),
						32'(result_if.overflow_flag));
				end
			end
			if (in_fire) begin
				got.opcode = instr_if.opcode;
				got.target = instr_if.target;
				got.number = instr_if.number;
				got.drain = 1'b0;
				expected_results.push_back(exec_instr(got));
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		int rights;
		foreach (m_stack[i]) m_stack[i] = '0;
		foreach (m_mem[i]) m_mem[i] = '0;

		// Directed: wrap on negate, saturation both ways, pc wrap, clamps
		push_instr(OP_RAND, '0, -1024, 1'b0);
		push_instr(OP_NEG, '0, 0, 1'b0);
		push_instr(OP_SUB_DIG, '0, 0, 1'b0);
		push_instr(OP_CMP_OVF, '0, 0, 1'b0);
		push_instr(OP_JUMP, '1, 0, 1'b0);
		push_instr(OP_SKIP, $urandom(), 0, 1'b0);
		push_instr(OP_USER, '0, 1023, 1'b0);
		push_instr(OP_ADD_DIG, '0, 0, 1'b0);
		push_instr(OP_TO_BAK, '0, 0, 1'b0);
		push_instr(OP_ADD_BAK, '0, 0, 1'b0);
		push_instr(OP_RAND, '0, -999, 1'b0);
		push_instr(OP_SWAP_BAK, '0, 0, 1'b0);
		push_instr(OP_NEG, '0, 0, 1'b0);
		push_instr(OP_ADD_BAK, '0, 0, 1'b0);
		push_instr(OP_SWAP_MEM, '0, 0, 1'b0);
		push_instr(OP_CUR_L, '0, 0, 1'b0);
		push_instr(OP_LOAD, '0, 0, 1'b0);
		repeat (3) push_instr(OP_DIG_UP, '0, 0, 1'b0);
		push_instr(OP_ADD_DIG, '0, 0, 1'b0);
		push_instr(OP_CMP_LTZ, '0, 0, 1'b0);
		push_instr(OP_CMP_EQZ, '0, 0, 1'b0);
		push_instr(OP_SKIP, '1, 0, 1'b0);
		push_call(1'b0);
		push_ret();
		push_instr(OP_EMIT, '0, 0, 1'b0);
		push_instr(OP_PAUSE, '0, 0, 1'b0);
		push_instr(OP_W'(OP_PAUSE + 1), '0, 0, 1'b0);

		push_random_block(250);

		// Fill the return stack to its last free slot and unwind it
		push_call(1'b1);
		while (gen_depth < STK_N - 1) begin
			if ($urandom_range(0, 4) == 0) push_random_op();
			else push_call(1'b0);
		end
		while (gen_depth > 0) begin
			if ($urandom_range(0, 4) == 0) push_random_op();
			else push_ret();
		end

		// Walk the cursor past the top cell, touching memory on the way
		push_instr(OP_CLR_POS, '0, 0, 1'b1);
		rights = 0;
		while (rights < MEM_N + 3) begin
			push_instr(OP_CUR_R, $urandom(), rand_num(), 1'b0);
			rights++;
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: push_instr(OP_SWAP_MEM, '0, 0, 1'b0);
					1: push_instr(OP_LOAD, '0, 0, 1'b0);
					2: push_instr(OP_RAND, '0, rand_num(), 1'b0);
					default: push_instr(OP_ADD_DIG, '0, 0, 1'b0);
				endcase
			end
		end

		push_random_block(250);

		// One halting event, then requests that only repeat the halted state
		case ($urandom_range(0, 3))
			0: push_instr(OP_STOP, $urandom(), rand_num(), 1'b0);
			1: push_instr(OP_END, $urandom(), rand_num(), 1'b0);
			2: begin
				while (gen_depth < STK_N - 1) push_call(1'b0);
				push_instr(OP_CALL, $urandom(), rand_num(), 1'b0);
			end
			default: begin
				while (gen_depth > 0) push_ret();
				push_instr(OP_RET, $urandom(), rand_num(), 1'b0);
			end
		endcase
		repeat (6) push_instr(OP_W'($urandom()), $urandom(), rand_num(), 1'b0);

		while (instr_q.size() != 0 || instr_if.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS accumulator_vm_execute_core");
		end else begin
			$display("FAIL accumulator_vm_execute_core");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("FAIL accumulator_vm_execute_core");
		$finish;
	end

endmodule
